### rtl/stlm_pkg.sv
// Shared types and constants of the sorted timer list manager.
// No dependencies; every other file of the block imports this package.
package stlm_pkg;

  localparam int SlotCountDef = 32;
  localparam logic [31:0] NoDeadline = 32'hffff_ffff;

  typedef enum logic [2:0] {
    ActAlloc = 3'd0,
    ActFree  = 3'd1,
    ActSet   = 3'd2,
    ActArm   = 3'd3,
    ActTick  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    SlotFree  = 2'd0,
    SlotAlloc = 2'd1,
    SlotArmed = 2'd2
  } slot_state_e;

  typedef enum logic [1:0] {
    KindAlloc  = 2'd0,
    KindFail   = 2'd1,
    KindExpiry = 2'd2,
    KindTask   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [4:0]         slot;
    logic [7:0]         target_queue;
    logic signed [31:0] message;
    logic [31:0]        delay;
  } stlm_in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [4:0]         out_slot;
    logic [7:0]         out_queue;
    logic signed [31:0] out_message;
    logic               last;
  } stlm_out_t;

  // Write enables of the slot memories.
  typedef struct packed {
    logic state;
    logic deadline;
    logic link;
    logic payload;
  } stlm_we_t;

endpackage

### rtl/stlm_ram.sv
// Slot memories: state, deadline, link, queue and message, one entry per slot.
// Depends on stlm_pkg. One shared read address, registered read data.
module stlm_ram import stlm_pkg::*; #(
  parameter int SLOT_COUNT = SlotCountDef,
  parameter int SW = $clog2(SLOT_COUNT)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [SW-1:0]      rd_addr_i,
  input  logic [SW-1:0]      wr_addr_i,
  input  stlm_we_t           we_i,
  input  slot_state_e        wr_state_i,
  input  logic [31:0]        wr_deadline_i,
  input  logic [SW-1:0]      wr_link_i,
  input  logic [7:0]         wr_queue_i,
  input  logic signed [31:0] wr_message_i,
  output slot_state_e        rd_state_o,
  output logic [31:0]        rd_deadline_o,
  output logic [SW-1:0]      rd_link_o,
  output logic [7:0]         rd_queue_o,
  output logic signed [31:0] rd_message_o
);

  slot_state_e        st_mem  [SLOT_COUNT];
  logic [31:0]        dl_mem  [SLOT_COUNT];
  logic [SW-1:0]      lk_mem  [SLOT_COUNT];
  logic [7:0]         q_mem   [SLOT_COUNT];
  logic signed [31:0] msg_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] st_valid_q;

  // A state entry that was never written reads as its reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= '0;
    end else if (we_i.state) begin
      st_valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i.state)    st_mem[wr_addr_i]  <= wr_state_i;
    if (we_i.deadline) dl_mem[wr_addr_i]  <= wr_deadline_i;
    if (we_i.link)     lk_mem[wr_addr_i]  <= wr_link_i;
    if (we_i.payload) begin
      q_mem[wr_addr_i]   <= wr_queue_i;
      msg_mem[wr_addr_i] <= wr_message_i;
    end
    if (st_valid_q[rd_addr_i]) begin
      rd_state_o <= st_mem[rd_addr_i];
    end else begin
      rd_state_o <= (rd_addr_i == '0) ? SlotArmed : SlotFree;
    end
    // The sentinel's deadline never changes.
    rd_deadline_o <= (rd_addr_i == '0) ? NoDeadline : dl_mem[rd_addr_i];
    rd_link_o     <= lk_mem[rd_addr_i];
    rd_queue_o    <= q_mem[rd_addr_i];
    rd_message_o  <= msg_mem[rd_addr_i];
  end

endmodule

### rtl/stlm_ctrl.sv
// Sequencer of the timer list: decodes actions, walks the list, emits results.
// Depends on stlm_pkg; drives the slot memories in stlm_ram.
module stlm_ctrl import stlm_pkg::*; #(
  parameter int SLOT_COUNT = SlotCountDef,
  parameter int SW = $clog2(SLOT_COUNT)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  stlm_in_t           in_i,
  input  logic               cfg_we_i,
  input  logic [5:0]         cfg_data_i,
  output logic               res_valid_o,
  output stlm_out_t          res_o,
  output logic [SW-1:0]      rd_addr_o,
  output logic [SW-1:0]      wr_addr_o,
  output stlm_we_t           we_o,
  output slot_state_e        wr_state_o,
  output logic [31:0]        wr_deadline_o,
  output logic [SW-1:0]      wr_link_o,
  output logic [7:0]         wr_queue_o,
  output logic signed [31:0] wr_message_o,
  input  slot_state_e        rd_state_i,
  input  logic [31:0]        rd_deadline_i,
  input  logic [SW-1:0]      rd_link_i,
  input  logic [7:0]         rd_queue_i,
  input  logic signed [31:0] rd_message_i
);

  typedef enum logic [10:0] {
    Idle    = 11'h001,
    AlChk   = 11'h002,
    FrChk   = 11'h004,
    SetWr   = 11'h008,
    ArChk   = 11'h010,
    ArHead  = 11'h020,
    ArWalk  = 11'h040,
    ArLinkS = 11'h080,
    TkChk   = 11'h100,
    TkFlush = 11'h200,
    TkSw    = 11'h400
  } fsm_e;

  fsm_e          state_q, state_d;
  stlm_in_t      op_q, op_d;
  logic [SW-1:0] idx_q, idx_d, prev_q, prev_d;
  logic [SW-1:0] pops_q, pops_d;
  logic [31:0]   dl_q, dl_d, tick_q, tick_d, earliest_q, earliest_d;
  logic [SW-1:0] head_q, head_d;
  logic [5:0]    task_q;
  logic          sw_q, sw_d, pend_v_q, pend_v_d, res_v_q, res_v_d;
  stlm_out_t     pend_q, pend_d, res_q, res_d, task_res;
  logic [SW-1:0] sidx;
  logic [31:0]   tick_inc, arm_dl;
  logic          in_ok;

  assign sidx     = SW'(op_q.slot);
  assign tick_inc = tick_q + 32'd1;
  assign arm_dl   = tick_q + op_q.delay;
  assign in_ok    = 32'(in_i.slot) < 32'(SLOT_COUNT);
  assign task_res = '{kind: KindTask, out_slot: task_q[4:0], out_queue: '0,
                      out_message: '0, last: 1'b1};

  assign busy        = (state_q != Idle);
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;
  assign wr_queue_o  = op_q.target_queue;
  assign wr_message_o = op_q.message;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    idx_d      = idx_q;
    prev_d     = prev_q;
    pops_d     = pops_q;
    dl_d       = dl_q;
    tick_d     = tick_q;
    earliest_d = earliest_q;
    head_d     = head_q;
    sw_d       = sw_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    res_v_d    = 1'b0;
    res_d      = res_q;
    rd_addr_o  = idx_q;
    wr_addr_o  = sidx;
    we_o       = '0;
    wr_state_o = SlotAlloc;
    wr_deadline_o = arm_dl;
    wr_link_o  = head_q;

    case (state_q)
      Idle: begin
        case (in_i.action)
          ActAlloc: rd_addr_o = '0;
          ActTick:  rd_addr_o = head_q;
          default:  rd_addr_o = SW'(in_i.slot);
        endcase
        if (start) begin
          op_d = in_i;
          case (in_i.action)
            ActAlloc: begin
              idx_d   = '0;
              state_d = AlChk;
            end
            ActFree: if (in_ok) state_d = FrChk;
            ActSet:  if (in_ok) state_d = SetWr;
            ActArm:  if (in_ok) state_d = ArChk;
            ActTick: begin
              tick_d = tick_inc;
              if (earliest_q <= tick_inc) begin
                idx_d    = head_q;
                pops_d   = '0;
                sw_d     = 1'b0;
                pend_v_d = 1'b0;
                state_d  = TkChk;
              end
            end
            default: ;
          endcase
        end
      end
      AlChk: begin
        if (rd_state_i == SlotFree) begin
          wr_addr_o  = idx_q;
          we_o.state = 1'b1;
          res_v_d = 1'b1;
          res_d   = '{kind: KindAlloc, out_slot: 5'(idx_q), out_queue: '0,
                      out_message: '0, last: 1'b1};
          state_d = Idle;
        end else if (idx_q == SW'(SLOT_COUNT - 1)) begin
          res_v_d = 1'b1;
          res_d   = '{kind: KindFail, out_slot: '0, out_queue: '0,
                      out_message: '0, last: 1'b1};
          state_d = Idle;
        end else begin
          idx_d     = idx_q + 1'b1;
          rd_addr_o = idx_q + 1'b1;
        end
      end
      FrChk: begin
        we_o.state = (rd_state_i != SlotArmed);
        wr_state_o = SlotFree;
        state_d    = Idle;
      end
      SetWr: begin
        we_o.payload = 1'b1;
        state_d      = Idle;
      end
      ArChk: begin
        rd_addr_o = head_q;
        if (rd_state_i == SlotArmed) begin
          state_d = Idle;
        end else begin
          dl_d          = arm_dl;
          we_o.state    = 1'b1;
          we_o.deadline = 1'b1;
          wr_state_o    = SlotArmed;
          // The earliest deadline always equals the head's deadline.
          if (arm_dl <= earliest_q) begin
            we_o.link  = 1'b1;
            head_d     = sidx;
            earliest_d = arm_dl;
            state_d    = Idle;
          end else begin
            state_d = ArHead;
          end
        end
      end
      ArHead: begin
        prev_d    = head_q;
        idx_d     = rd_link_i;
        rd_addr_o = rd_link_i;
        state_d   = ArWalk;
      end
      ArWalk: begin
        if (dl_q <= rd_deadline_i || idx_q == '0) begin
          wr_addr_o = prev_q;
          wr_link_o = sidx;
          we_o.link = 1'b1;
          state_d   = ArLinkS;
        end else begin
          prev_d    = idx_q;
          idx_d     = rd_link_i;
          rd_addr_o = rd_link_i;
        end
      end
      ArLinkS: begin
        wr_link_o = idx_q;
        we_o.link = 1'b1;
        state_d   = Idle;
      end
      TkChk: begin
        if (idx_q != '0 && rd_deadline_i <= tick_q && pops_q < SW'(SLOT_COUNT - 1)) begin
          wr_addr_o  = idx_q;
          we_o.state = 1'b1;
          if (7'(idx_q) == 7'(task_q)) begin
            sw_d = 1'b1;
          end else begin
            // Hold one message back so that the final one can carry last.
            if (pend_v_q) begin
              res_v_d = 1'b1;
              res_d   = pend_q;
            end
            pend_v_d = 1'b1;
            pend_d   = '{kind: KindExpiry, out_slot: 5'(idx_q), out_queue: rd_queue_i,
                         out_message: rd_message_i, last: 1'b0};
          end
          pops_d    = pops_q + 1'b1;
          idx_d     = rd_link_i;
          rd_addr_o = rd_link_i;
        end else begin
          head_d     = idx_q;
          earliest_d = rd_deadline_i;
          state_d    = TkFlush;
        end
      end
      TkFlush: begin
        state_d = Idle;
        if (pend_v_q) begin
          res_v_d      = 1'b1;
          res_d        = pend_q;
          res_d.last   = !sw_q;
          pend_v_d     = 1'b0;
          if (sw_q) state_d = TkSw;
        end else if (sw_q) begin
          res_v_d = 1'b1;
          res_d   = task_res;
        end
      end
      TkSw: begin
        res_v_d = 1'b1;
        res_d   = task_res;
        state_d = Idle;
      end
      default: state_d = Idle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= Idle;
      tick_q     <= '0;
      earliest_q <= NoDeadline;
      head_q     <= '0;
      task_q     <= 6'd32;
      sw_q       <= 1'b0;
      pend_v_q   <= 1'b0;
      res_v_q    <= 1'b0;
      pops_q     <= '0;
    end else begin
      state_q    <= state_d;
      tick_q     <= tick_d;
      earliest_q <= earliest_d;
      head_q     <= head_d;
      sw_q       <= sw_d;
      pend_v_q   <= pend_v_d;
      res_v_q    <= res_v_d;
      pops_q     <= pops_d;
      if (cfg_we_i) task_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    idx_q  <= idx_d;
    prev_q <= prev_d;
    dl_q   <= dl_d;
    pend_q <= pend_d;
    res_q  <= res_d;
  end

endmodule

### rtl/sorted_timer_list_manager.sv
// Sorted timer list manager: a pool of timer slots kept in a deadline-sorted list.
//
// Input: a word on in_i is taken at a rising edge where start is high and busy
// is low. Actions are allocate, free, set target and message, arm and tick.
// Configuration: cfg_we_i writes cfg_data_i into the task slot register; write
// it only while busy is low.
// Output: each result word sits on res_o for one cycle with res_valid_o high;
// the receiver cannot stall, and the final word of an action carries last.
// Sequencing: free and set each do one memory write (free skips an armed slot);
// a tick with nothing due only advances the count. Allocate scans one slot per
// cycle through the state memory. Arm walks the list one memory read per cycle.
// An expiring tick pops due slots in list order, then sends the held-back
// message and, if the task slot expired, a task word. Results are registered.
// Reset clears the count, empties the list down to the sentinel slot 0, frees
// all other slots and sets the task slot to none; no clearing pass is needed.
// Depends on stlm_pkg, stlm_ctrl and stlm_ram.
module sorted_timer_list_manager import stlm_pkg::*; #(
  parameter int SLOT_COUNT = SlotCountDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  stlm_in_t   in_i,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_data_i,
  output logic       res_valid_o,
  output stlm_out_t  res_o
);

  localparam int SW = $clog2(SLOT_COUNT);

  logic [SW-1:0]      rd_addr, wr_addr, wr_link, rd_link;
  stlm_we_t           we;
  slot_state_e        wr_state, rd_state;
  logic [31:0]        wr_deadline, rd_deadline;
  logic [7:0]         wr_queue, rd_queue;
  logic signed [31:0] wr_message, rd_message;

  stlm_ctrl #(.SLOT_COUNT(SLOT_COUNT), .SW(SW)) u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .in_i, .cfg_we_i, .cfg_data_i,
    .res_valid_o, .res_o,
    .rd_addr_o(rd_addr), .wr_addr_o(wr_addr), .we_o(we), .wr_state_o(wr_state),
    .wr_deadline_o(wr_deadline), .wr_link_o(wr_link), .wr_queue_o(wr_queue),
    .wr_message_o(wr_message), .rd_state_i(rd_state), .rd_deadline_i(rd_deadline),
    .rd_link_i(rd_link), .rd_queue_i(rd_queue), .rd_message_i(rd_message)
  );

  stlm_ram #(.SLOT_COUNT(SLOT_COUNT), .SW(SW)) u_ram (
    .clk_i, .rst_ni,
    .rd_addr_i(rd_addr), .wr_addr_i(wr_addr), .we_i(we), .wr_state_i(wr_state),
    .wr_deadline_i(wr_deadline), .wr_link_i(wr_link), .wr_queue_i(wr_queue),
    .wr_message_i(wr_message), .rd_state_o(rd_state), .rd_deadline_o(rd_deadline),
    .rd_link_o(rd_link), .rd_queue_o(rd_queue), .rd_message_o(rd_message)
  );

endmodule

### rtl/stlm_chk.sv
// Port-level checks of the sorted timer list manager, bound to the top level.
// Depends on stlm_pkg.
module stlm_chk import stlm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input stlm_in_t  in_i,
  input logic      res_valid_o,
  input stlm_out_t res_o
);

  // The final word of an action is shown once the block is free again.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |-> !busy) else $error("last word while busy");

  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy) else $error("word without last after action");

  a_alloc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && in_i.action == ActAlloc |=> busy) else $error("allocate too short");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind == KindAlloc || res_o.kind == KindFail ||
                    res_o.kind == KindTask) |-> res_o.last)
    else $error("single-word result without last");

endmodule

bind sorted_timer_list_manager stlm_chk u_stlm_chk (
  .clk_i, .rst_ni, .start, .busy, .in_i, .res_valid_o, .res_o
);
